>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the text capture block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while in reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lcdcap_pkg.sv
// ----------------------------------------------------------------------------
// lcdcap_pkg
// Types, constants and helpers for the LCD nibble bus text capture block.
// ----------------------------------------------------------------------------
package lcdcap_pkg;

  // Text store geometry.
  localparam int TEXT_ROWS    = 4;
  localparam int TEXT_COLUMNS = 40;
  localparam int TEXT_CELLS   = TEXT_ROWS * TEXT_COLUMNS;
  localparam int CELL_AW      = $clog2(TEXT_CELLS);

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [5:0] LAST_COLUMN_LIMIT = 6'(TEXT_COLUMNS);

  // Display address map.
  localparam logic [6:0] ADDR_WRAP_START = 7'h68;
  localparam logic [6:0] ADDR_GAP_START  = 7'h28;
  localparam logic [6:0] ADDR_LINE2_BASE = 7'h40;
  localparam logic [5:0] FOLD_COLUMN     = 6'd20;
  localparam logic [2:0] ROWS_FOLDED     = 3'd4;

  // Controller command codes.
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_RETURN_HOME = 8'h02;
  localparam logic [7:0] CMD_HOME_MASK   = 8'hfe;
  localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;

  // Operation codes.
  localparam logic OP_PIN_WRITE = 1'b0;
  localparam logic OP_READ_CELL = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DISPLAY_ROWS = 1'b0;
  localparam logic CFG_MAX_COLUMNS  = 1'b1;

  localparam logic [2:0] DISPLAY_ROWS_RESET = 3'd2;
  localparam logic [5:0] MAX_COLUMNS_RESET  = 6'd40;

  // One input item.
  typedef struct packed {
    logic       op;
    logic [7:0] pin_byte;
    logic [1:0] read_row;
    logic [5:0] read_column;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] cell_char;
    logic       backlight_on;
    logic [5:0] columns_used;
    logic [6:0] ddram_address;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic execute;
  } dp_cmd_t;

  // Flat store index of a row and column: row * TEXT_COLUMNS + column.
  function automatic logic [CELL_AW-1:0] cell_index(input logic [1:0] row,
                                                    input logic [5:0] col);
    logic [CELL_AW-1:0] r;
    r = CELL_AW'(row);
    return CELL_AW'(r * CELL_AW'(TEXT_COLUMNS) + CELL_AW'(col));
  endfunction

endpackage

>>> rtl/hd44780_nibble_bus_text_capture.sv
// ----------------------------------------------------------------------------
// hd44780_nibble_bus_text_capture
// Follows the pin bytes written to an LCD backpack expander, decodes them as
// a 4-bit character LCD controller would, and keeps the displayed text.
//
//   Channel  Direction  Handshake                  Payload
//   item     in         item_valid / item_stall    lcdcap_pkg::in_item_t
//   result   out        result_valid / result_stall lcdcap_pkg::out_item_t
//   cfg      in         cfg_write                  cfg_index, cfg_data
//
// The accept cycle reads the text store into its read register; the execute
// state then runs the item and loads the result register.
// A clear command runs the same way; it drops all cell valid bits.
// Reset clears the cell valid bits directly; no clearing pass runs over the store.
// A stalled result holds the item in execute until the result register frees.
// ----------------------------------------------------------------------------
module hd44780_nibble_bus_text_capture (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  lcdcap_pkg::in_item_t  item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output lcdcap_pkg::out_item_t result,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [5:0]            cfg_data
);
  import lcdcap_pkg::*;

  dp_cmd_t cmd;

  // Sequencing and handshake.
  lcdcap_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // Decode, text store and result register.
  lcdcap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

>>> rtl/lcdcap_dp.sv
// ----------------------------------------------------------------------------
// lcdcap_dp
// Datapath: configuration registers, nibble pairing, address counter, text
// store with per-cell valid bits, and the result register.
// ----------------------------------------------------------------------------
module lcdcap_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdcap_pkg::dp_cmd_t  cmd,
  input  lcdcap_pkg::in_item_t item,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [5:0]           cfg_data,
  output lcdcap_pkg::out_item_t result
);
  import lcdcap_pkg::*;

  // Configuration.
  logic [2:0] display_rows;
  logic [5:0] max_columns;

  // Controller state.
  logic       register_select;
  logic [8:0] nibble_acc;
  logic [6:0] address_counter;
  logic [5:0] used_columns;
  logic       backlight;

  // Text store; a cell whose valid bit is clear reads as a space.
  logic [7:0]            text_mem [TEXT_CELLS];
  logic [TEXT_CELLS-1:0] cell_valid;

  // Captured item and registered read port.
  in_item_t   item_q;
  logic [7:0] rd_data;
  logic       rd_valid;
  logic       rd_in_range;

  // Read address from the incoming item.
  logic               rd_col_ok;
  logic [CELL_AW-1:0] rd_idx;

  // Byte decode.
  logic       take;
  logic       rs;
  logic [8:0] acc_base;
  logic [8:0] acc_join;
  logic       pair_done;
  logic [7:0] byte_val;
  logic       do_data;
  logic       do_cmd;

  // Data address mapping.
  logic [6:0]         addr_wrap;
  logic [6:0]         addr_map;
  logic [5:0]         col_raw;
  logic [1:0]         row_raw;
  logic               fold;
  logic [5:0]         col;
  logic [1:0]         row;
  logic               in_store;
  logic [CELL_AW-1:0] wr_idx;
  logic [6:0]         col_plus;
  logic [5:0]         used_cap;

  // Next state.
  logic       register_select_next;
  logic [8:0] nibble_acc_next;
  logic [6:0] address_counter_next;
  logic [5:0] used_columns_next;
  logic       backlight_next;
  logic       clear_store;
  logic       store_write;

  // Read address.
  always_comb begin
    rd_col_ok = (item.read_column < LAST_COLUMN_LIMIT);
    rd_idx    = rd_col_ok ? cell_index(item.read_row, item.read_column) : '0;
  end

  // Pin byte decode and nibble pairing.
  always_comb begin
    take      = (item_q.op == OP_PIN_WRITE) && item_q.pin_byte[2] && !item_q.pin_byte[1];
    rs        = item_q.pin_byte[0];
    acc_base  = (rs != register_select) ? 9'd1 : nibble_acc;
    acc_join  = {acc_base[4:0], item_q.pin_byte[7:4]};
    pair_done = acc_join[8];
    byte_val  = acc_join[7:0];
    do_data   = take && pair_done && rs;
    do_cmd    = take && pair_done && !rs;
  end

  // Data address wrap, row folding and used column tracking.
  always_comb begin
    addr_wrap = (address_counter >= ADDR_WRAP_START) ? 7'd0 : address_counter;
    addr_map  = (addr_wrap >= ADDR_GAP_START && addr_wrap < ADDR_LINE2_BASE) ?
                ADDR_LINE2_BASE : addr_wrap;
    col_raw   = addr_map[5:0];
    row_raw   = {1'b0, addr_map[6]};
    fold      = (display_rows == ROWS_FOLDED) && (col_raw >= FOLD_COLUMN);
    col       = fold ? (col_raw - FOLD_COLUMN) : col_raw;
    row       = fold ? (row_raw + 2'd2) : row_raw;
    in_store  = (col < LAST_COLUMN_LIMIT);
    wr_idx    = cell_index(row, col);
    col_plus  = {1'b0, col} + 7'd1;
    used_cap  = (col_plus > {1'b0, max_columns}) ? max_columns : col_plus[5:0];
  end

  // Next values of the controller state.
  always_comb begin
    register_select_next = register_select;
    nibble_acc_next      = nibble_acc;
    address_counter_next = address_counter;
    used_columns_next    = used_columns;
    backlight_next       = backlight;
    clear_store          = 1'b0;
    store_write          = 1'b0;
    if (take) begin
      backlight_next       = item_q.pin_byte[3];
      register_select_next = rs;
      nibble_acc_next      = pair_done ? 9'd1 : acc_join;
    end
    if (do_data) begin
      store_write          = in_store;
      address_counter_next = addr_map + 7'd1;
      if (col >= used_columns) begin
        used_columns_next = used_cap;
      end
    end
    if (do_cmd) begin
      if ((byte_val & CMD_SET_ADDRESS) != 8'h00) begin
        address_counter_next = byte_val[6:0];
      end else if (byte_val == CMD_CLEAR) begin
        clear_store          = 1'b1;
        address_counter_next = '0;
      end else if ((byte_val & CMD_HOME_MASK) == CMD_RETURN_HOME) begin
        address_counter_next = '0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_rows <= DISPLAY_ROWS_RESET;
      max_columns  <= MAX_COLUMNS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DISPLAY_ROWS: display_rows <= cfg_data[2:0];
        CFG_MAX_COLUMNS:  max_columns  <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Controller state and cell valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      register_select <= 1'b0;
      nibble_acc      <= 9'd1;
      address_counter <= '0;
      used_columns    <= '0;
      backlight       <= 1'b0;
      cell_valid      <= '0;
    end else if (cmd.execute) begin
      register_select <= register_select_next;
      nibble_acc      <= nibble_acc_next;
      address_counter <= address_counter_next;
      used_columns    <= used_columns_next;
      backlight       <= backlight_next;
      if (clear_store) begin
        cell_valid <= '0;
      end else if (store_write) begin
        cell_valid[wr_idx] <= 1'b1;
      end
    end
  end

  // Text store write port.
  always_ff @(posedge clk) begin
    if (cmd.execute && store_write) begin
      text_mem[wr_idx] <= byte_val;
    end
  end

  // Item capture and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q      <= item;
      rd_data     <= text_mem[rd_idx];
      rd_valid    <= cell_valid[rd_idx];
      rd_in_range <= rd_col_ok;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (item_q.op == OP_READ_CELL && rd_in_range) begin
        result.cell_char <= rd_valid ? rd_data : SPACE_CHAR;
      end else begin
        result.cell_char <= '0;
      end
      result.backlight_on  <= backlight_next;
      result.columns_used  <= used_columns_next;
      result.ddram_address <= address_counter_next;
    end
  end

endmodule

>>> rtl/lcdcap_ctrl.sv
// ----------------------------------------------------------------------------
// lcdcap_ctrl
// Controller: sequences accept and execute for one item at a time and owns
// the handshake flags of both channels.
// ----------------------------------------------------------------------------
module lcdcap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  output lcdcap_pkg::dp_cmd_t cmd
);
  import lcdcap_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  // The result register may load when empty or when its transfer completes.
  always_comb begin
    out_free    = !result_valid || !result_stall;
    item_stall  = (state != ST_IDLE);
    cmd.accept  = (state == ST_IDLE) && item_valid;
    cmd.execute = (state == ST_EXEC) && out_free;
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_EXEC;
          end
          if (!result_stall) begin
            result_valid <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state        <= ST_IDLE;
            result_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lcdcap_chk.sv
// ----------------------------------------------------------------------------
// lcdcap_chk
// Port-level checks of the text capture block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdcap_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input lcdcap_pkg::out_item_t result
);
  import lcdcap_pkg::*;

  logic in_xfer;
  logic out_held;
  logic cols_ok;

  // Handshake and range terms used by the checks below.
  assign in_xfer  = item_valid && !item_stall;
  assign out_held = result_valid && result_stall;
  assign cols_ok  = (result.columns_used <= LAST_COLUMN_LIMIT);

  // A stalled result keeps its payload.
  `CHK_ASSERT(a_result_hold, out_held |=> result_valid && $stable(result), "held result changed")

  // One item at a time: the cycle after a transfer in, input is stalled.
  `CHK_ASSERT(a_one_item, in_xfer |=> item_stall, "second item accepted during execute")

  // A new result only appears after an execute cycle.
  `CHK_ASSERT(a_result_source, $rose(result_valid) |-> $past(item_stall), "result without an item")

  // The used column count never exceeds the store width.
  `CHK_ASSERT(a_columns_range, result_valid |-> cols_ok, "columns_used out of range")

  // Reset empties the result register.
  `CHK_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

endmodule

bind hd44780_nibble_bus_text_capture lcdcap_chk u_lcdcap_chk (.*);
